// File: hw/rtl/gmdb_pkg.sv
package gmdb_pkg;

    localparam int DEF_MAX_GRID_W = 256;
    localparam int DEF_MAX_GRID_H = 256;

    localparam int LUMA_W  = 8;
    localparam int BOX_W   = 8;
    localparam int COUNT_W = 17;
    localparam int DIM_W   = 9;

    localparam logic [DIM_W-1:0]   RST_GRID_W    = 9'd240;
    localparam logic [DIM_W-1:0]   RST_GRID_H    = 9'd135;
    localparam logic [LUMA_W-1:0]  RST_THRESHOLD = 8'd25;
    localparam logic [COUNT_W-1:0] RST_MIN_CELLS = 17'd8;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        REG_GRID_W    = 2'd0,
        REG_GRID_H    = 2'd1,
        REG_THRESHOLD = 2'd2,
        REG_MIN_CELLS = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [DIM_W-1:0]   grid_width;
        logic [DIM_W-1:0]   grid_height;
        logic [LUMA_W-1:0]  diff_threshold;
        logic [COUNT_W-1:0] min_cells;
    } t_cfg;

    typedef struct packed {
        logic last;
        logic primed;
    } t_item_ctl;

endpackage

// File: hw/rtl/gmdb_fifo.sv
module gmdb_fifo
    import gmdb_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [WIDTH-1:0]    i_push_data,
    input  logic                i_pop,
    output logic [WIDTH-1:0]    o_pop_data,
    output logic                o_nonempty,
    output logic [QUEUE_PW:0]   o_count
);

    logic [WIDTH-1:0]    r_mem [QUEUE_DEPTH];
    logic [QUEUE_PW-1:0] r_wr;
    logic [QUEUE_PW-1:0] r_rd;
    logic [QUEUE_PW:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    assign o_pop_data = r_mem[r_rd];
    assign o_nonempty = (r_count != '0);
    assign o_count    = r_count;

endmodule

// File: hw/rtl/gmdb_front.sv
module gmdb_front
    import gmdb_pkg::*;
#(
    parameter int MAX_GRID_W = DEF_MAX_GRID_W,
    parameter int MAX_GRID_H = DEF_MAX_GRID_H,
    localparam int CW = (MAX_GRID_W > 1) ? $clog2(MAX_GRID_W) : 1,
    localparam int RW = (MAX_GRID_H > 1) ? $clog2(MAX_GRID_H) : 1,
    localparam int DEPTH = MAX_GRID_W * MAX_GRID_H,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_restart,
    input  logic                i_valid,
    input  logic [LUMA_W-1:0]   i_luma,
    output logic                o_ready,
    input  logic [QUEUE_PW:0]   i_level,
    output logic                o_push,
    output t_item_ctl           o_ctl,
    output logic [LUMA_W-1:0]   o_cur,
    output logic [LUMA_W-1:0]   o_prev,
    output logic [CW-1:0]       o_col,
    output logic [RW-1:0]       o_row
);

    localparam int CMPW_C = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;
    localparam int CMPW_R = (RW + 1 > DIM_W) ? RW + 1 : DIM_W;

    logic [LUMA_W-1:0] r_mem [DEPTH];

    logic [CW-1:0]     r_col;
    logic [RW-1:0]     r_row;
    logic [AW-1:0]     r_addr;
    logic              r_primed;
    logic              r_s1_valid;
    t_item_ctl         r_s1_ctl;
    logic [LUMA_W-1:0] r_s1_cur;
    logic [LUMA_W-1:0] r_s1_prev;
    logic [CW-1:0]     r_s1_col;
    logic [RW-1:0]     r_s1_row;

    logic [CMPW_C-1:0] w_ext;
    logic [CMPW_R-1:0] h_ext;
    logic [CW-1:0]     col_lim;
    logic [RW-1:0]     row_lim;
    logic [QUEUE_PW+1:0] occupancy;
    logic              accept;
    logic              last_col;
    logic              last_cell;

    // clamp grid size: zero acts as one, oversize acts as maximum
    always_comb begin
        w_ext = CMPW_C'(i_cfg.grid_width);
        h_ext = CMPW_R'(i_cfg.grid_height);
        if (w_ext == '0) begin
            col_lim = '0;
        end else if (w_ext > CMPW_C'(MAX_GRID_W)) begin
            col_lim = CW'(MAX_GRID_W - 1);
        end else begin
            col_lim = CW'(w_ext - 1'b1);
        end
        if (h_ext == '0) begin
            row_lim = '0;
        end else if (h_ext > CMPW_R'(MAX_GRID_H)) begin
            row_lim = RW'(MAX_GRID_H - 1);
        end else begin
            row_lim = RW'(h_ext - 1'b1);
        end
    end

    assign occupancy = {1'b0, i_level} + {{(QUEUE_PW + 1){1'b0}}, r_s1_valid};
    assign o_ready   = (occupancy < (QUEUE_PW + 2)'(QUEUE_DEPTH));
    assign accept    = i_valid && o_ready;
    assign last_col  = (r_col == col_lim);
    assign last_cell = last_col && (r_row == row_lim);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_addr     <= '0;
            r_primed   <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            if (i_restart) begin
                r_col    <= '0;
                r_row    <= '0;
                r_addr   <= '0;
                r_primed <= 1'b0;
            end else if (accept) begin
                if (last_cell) begin
                    r_col    <= '0;
                    r_row    <= '0;
                    r_addr   <= '0;
                    r_primed <= 1'b1;
                end else if (last_col) begin
                    r_col  <= '0;
                    r_row  <= r_row + 1'b1;
                    r_addr <= r_addr + 1'b1;
                end else begin
                    r_col  <= r_col + 1'b1;
                    r_addr <= r_addr + 1'b1;
                end
            end
        end
    end

    // previous-frame store, read old value and write new one per cell
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_prev     <= r_mem[r_addr];
            r_mem[r_addr] <= i_luma;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ctl.last   <= last_cell;
            r_s1_ctl.primed <= r_primed;
            r_s1_cur        <= i_luma;
            r_s1_col        <= r_col;
            r_s1_row        <= r_row;
        end
    end

    assign o_push = r_s1_valid;
    assign o_ctl  = r_s1_ctl;
    assign o_cur  = r_s1_cur;
    assign o_prev = r_s1_prev;
    assign o_col  = r_s1_col;
    assign o_row  = r_s1_row;

endmodule

// File: hw/rtl/gmdb_back.sv
module gmdb_back
    import gmdb_pkg::*;
#(
    parameter int MAX_GRID_W = DEF_MAX_GRID_W,
    parameter int MAX_GRID_H = DEF_MAX_GRID_H,
    localparam int CW = (MAX_GRID_W > 1) ? $clog2(MAX_GRID_W) : 1,
    localparam int RW = (MAX_GRID_H > 1) ? $clog2(MAX_GRID_H) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_restart,
    input  logic                i_valid,
    input  t_item_ctl           i_ctl,
    input  logic [LUMA_W-1:0]   i_cur,
    input  logic [LUMA_W-1:0]   i_prev,
    input  logic [CW-1:0]       i_col,
    input  logic [RW-1:0]       i_row,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_active,
    output logic [BOX_W-1:0]    o_left,
    output logic [BOX_W-1:0]    o_top,
    output logic [BOX_W-1:0]    o_right,
    output logic [BOX_W-1:0]    o_bottom,
    output logic [COUNT_W-1:0]  o_count
);

    logic [CW-1:0]      r_lc;
    logic [CW-1:0]      r_gc;
    logic [RW-1:0]      r_lr;
    logic [RW-1:0]      r_gr;
    logic [COUNT_W-1:0] r_total;
    logic [CW-1:0]      n_lc;
    logic [CW-1:0]      n_gc;
    logic [RW-1:0]      n_lr;
    logic [RW-1:0]      n_gr;
    logic [COUNT_W-1:0] n_total;

    logic               r_out_valid;
    logic               r_active;
    logic [BOX_W-1:0]   r_left;
    logic [BOX_W-1:0]   r_top;
    logic [BOX_W-1:0]   r_right;
    logic [BOX_W-1:0]   r_bottom;
    logic [COUNT_W-1:0] r_count;

    logic [LUMA_W-1:0]  diff;
    logic               changed;
    logic               active;
    logic [CW+BOX_W-1:0] lc_ext;
    logic [CW+BOX_W-1:0] gc_ext;
    logic [RW+BOX_W-1:0] lr_ext;
    logic [RW+BOX_W-1:0] gr_ext;

    assign diff    = (i_cur > i_prev) ? i_cur - i_prev : i_prev - i_cur;
    assign changed = i_ctl.primed && (diff > i_cfg.diff_threshold);
    assign o_pop   = i_valid && (!i_ctl.last || !r_out_valid || i_ready);

    always_comb begin
        n_lc    = r_lc;
        n_gc    = r_gc;
        n_lr    = r_lr;
        n_gr    = r_gr;
        n_total = r_total;
        if (changed) begin
            n_total = r_total + 1'b1;
            if (r_total == '0) begin
                n_lc = i_col;
                n_gc = i_col;
                n_lr = i_row;
                n_gr = i_row;
            end else begin
                if (i_col < r_lc) n_lc = i_col;
                if (i_col > r_gc) n_gc = i_col;
                if (i_row < r_lr) n_lr = i_row;
                if (i_row > r_gr) n_gr = i_row;
            end
        end
    end

    assign active = i_ctl.primed && (n_total != '0) && (n_total >= i_cfg.min_cells);
    assign lc_ext = {{BOX_W{1'b0}}, n_lc};
    assign gc_ext = {{BOX_W{1'b0}}, n_gc};
    assign lr_ext = {{BOX_W{1'b0}}, n_lr};
    assign gr_ext = {{BOX_W{1'b0}}, n_gr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lc        <= '0;
            r_gc        <= '0;
            r_lr        <= '0;
            r_gr        <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_restart || (o_pop && i_ctl.last)) begin
                r_lc    <= '0;
                r_gc    <= '0;
                r_lr    <= '0;
                r_gr    <= '0;
                r_total <= '0;
            end else if (o_pop) begin
                r_lc    <= n_lc;
                r_gc    <= n_gc;
                r_lr    <= n_lr;
                r_gr    <= n_gr;
                r_total <= n_total;
            end
            if (o_pop && i_ctl.last) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_ctl.last) begin
            r_active <= active;
            r_left   <= active ? lc_ext[BOX_W-1:0] : '0;
            r_top    <= active ? lr_ext[BOX_W-1:0] : '0;
            r_right  <= active ? gc_ext[BOX_W-1:0] : '0;
            r_bottom <= active ? gr_ext[BOX_W-1:0] : '0;
            r_count  <= i_ctl.primed ? n_total : '0;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_active = r_active;
    assign o_left   = r_left;
    assign o_top    = r_top;
    assign o_right  = r_right;
    assign o_bottom = r_bottom;
    assign o_count  = r_count;

endmodule

// File: hw/rtl/grid_motion_diff_bbox.sv
// Frame-difference motion detector over a grid of downsampled luma cells. Cells arrive in
// raster order, one per stream transaction, and the block takes one cell every clock while
// its queue has room: each cell costs one read and one write of the previous-frame store, both
// issued in the cycle the cell is taken. A cell counts as changed when its absolute difference
// from the stored cell exceeds diff_threshold; the last cell of a frame yields one result,
// carrying the changed count and, when at least one and at least min_cells cells changed, the
// inclusive bounding box in grid coordinates. The store is not cleared: after reset or any
// register write the first frame only fills it and reports inactive with a count of zero.
// Registers lie at byte addresses 0 (grid_width), 4 (grid_height), 8 (diff_threshold) and 12
// (min_cells); a write restarts the frame at cell (0,0), so write only between transactions.
module grid_motion_diff_bbox
    import gmdb_pkg::*;
#(
    parameter int MAX_GRID_W = DEF_MAX_GRID_W,
    parameter int MAX_GRID_H = DEF_MAX_GRID_H
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // cell_luma
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // box_left, box_top, box_right, box_bottom, changed_cells
    output logic [0:0]  m_axis_tuser,   // motion_active
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = (MAX_GRID_W > 1) ? $clog2(MAX_GRID_W) : 1;
    localparam int RW = (MAX_GRID_H > 1) ? $clog2(MAX_GRID_H) : 1;
    localparam int QW = 2 + 2 * LUMA_W + CW + RW;

    t_cfg r_cfg;
    logic cfg_write;
    t_reg_idx reg_idx;

    logic               push;
    t_item_ctl          push_ctl;
    logic [LUMA_W-1:0]  push_cur;
    logic [LUMA_W-1:0]  push_prev;
    logic [CW-1:0]      push_col;
    logic [RW-1:0]      push_row;
    logic [QW-1:0]      q_in;
    logic [QW-1:0]      q_out;
    logic               q_nonempty;
    logic [QUEUE_PW:0]  q_count;
    logic               pop;

    t_item_ctl          pop_ctl;
    logic [LUMA_W-1:0]  pop_cur;
    logic [LUMA_W-1:0]  pop_prev;
    logic [CW-1:0]      pop_col;
    logic [RW-1:0]      pop_row;

    logic               res_active;
    logic [BOX_W-1:0]   res_left;
    logic [BOX_W-1:0]   res_top;
    logic [BOX_W-1:0]   res_right;
    logic [BOX_W-1:0]   res_bottom;
    logic [COUNT_W-1:0] res_count;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid_width     <= RST_GRID_W;
            r_cfg.grid_height    <= RST_GRID_H;
            r_cfg.diff_threshold <= RST_THRESHOLD;
            r_cfg.min_cells      <= RST_MIN_CELLS;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_GRID_W:    r_cfg.grid_width     <= pwdata[DIM_W-1:0];
                REG_GRID_H:    r_cfg.grid_height    <= pwdata[DIM_W-1:0];
                REG_THRESHOLD: r_cfg.diff_threshold <= pwdata[LUMA_W-1:0];
                REG_MIN_CELLS: r_cfg.min_cells      <= pwdata[COUNT_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_GRID_W:    prdata = 32'(r_cfg.grid_width);
            REG_GRID_H:    prdata = 32'(r_cfg.grid_height);
            REG_THRESHOLD: prdata = 32'(r_cfg.diff_threshold);
            REG_MIN_CELLS: prdata = 32'(r_cfg.min_cells);
        endcase
    end

    gmdb_front #(
        .MAX_GRID_W (MAX_GRID_W),
        .MAX_GRID_H (MAX_GRID_H)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_restart (cfg_write),
        .i_valid   (s_axis_tvalid),
        .i_luma    (s_axis_tdata),
        .o_ready   (s_axis_tready),
        .i_level   (q_count),
        .o_push    (push),
        .o_ctl     (push_ctl),
        .o_cur     (push_cur),
        .o_prev    (push_prev),
        .o_col     (push_col),
        .o_row     (push_row)
    );

    assign q_in = {push_ctl, push_cur, push_prev, push_col, push_row};

    gmdb_fifo #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (q_in),
        .i_pop       (pop),
        .o_pop_data  (q_out),
        .o_nonempty  (q_nonempty),
        .o_count     (q_count)
    );

    assign {pop_ctl, pop_cur, pop_prev, pop_col, pop_row} = q_out;

    gmdb_back #(
        .MAX_GRID_W (MAX_GRID_W),
        .MAX_GRID_H (MAX_GRID_H)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_restart (cfg_write),
        .i_valid   (q_nonempty),
        .i_ctl     (pop_ctl),
        .i_cur     (pop_cur),
        .i_prev    (pop_prev),
        .i_col     (pop_col),
        .i_row     (pop_row),
        .o_pop     (pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_active  (res_active),
        .o_left    (res_left),
        .o_top     (res_top),
        .o_right   (res_right),
        .o_bottom  (res_bottom),
        .o_count   (res_count)
    );

    assign m_axis_tdata = {7'b0, res_count, res_bottom, res_right, res_top, res_left};
    assign m_axis_tuser = res_active;

endmodule

// File: bench/tb_grid_motion_diff_bbox.sv
`timescale 1ns / 100ps

module tb_grid_motion_diff_bbox;
    import gmdb_pkg::*;

    typedef struct packed {
        logic               active;
        logic [BOX_W-1:0]   left;
        logic [BOX_W-1:0]   top;
        logic [BOX_W-1:0]   right;
        logic [BOX_W-1:0]   bottom;
        logic [COUNT_W-1:0] count;
    } t_motion_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // cell_luma
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;   // box_left, box_top, box_right, box_bottom, changed_cells
    logic [0:0]  m_axis_tuser;   // motion_active
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    grid_motion_diff_bbox dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // predictor state
    logic [LUMA_W-1:0]  prev_cells [0:65535];
    bit                 grid_primed;
    int                 cur_col, cur_row;
    int                 least_col, least_row, great_col, great_row;
    logic [COUNT_W-1:0] change_count;
    logic [DIM_W-1:0]   cfg_width, cfg_height;
    logic [LUMA_W-1:0]  cfg_threshold;
    logic [COUNT_W-1:0] cfg_min_cells;

    t_motion_result frame_results_due [$];
    t_motion_result want;

    int  mismatches;
    bit  tx_idle_en;
    bit  rx_idle_en;
    bit  hold_request;
    int  hold_left;
    int  rx_stall_left;
    int  change_pct;
    int  rand_items;
    int  rand_frames;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int clamp_grid(logic [DIM_W-1:0] v, int lim);
        if (v == 0)
            return 1;
        if (v > lim)
            return lim;
        return v;
    endfunction

    task automatic restart_frame_model();
        cur_col = 0;
        cur_row = 0;
        least_col = 0;
        least_row = 0;
        great_col = 0;
        great_row = 0;
        change_count = '0;
    endtask

    task automatic reset_model();
        foreach (prev_cells[i])
            prev_cells[i] = '0;
        grid_primed = 1'b0;
        restart_frame_model();
        cfg_width = RST_GRID_W;
        cfg_height = RST_GRID_H;
        cfg_threshold = RST_THRESHOLD;
        cfg_min_cells = RST_MIN_CELLS;
    endtask

    task automatic predict_cell(logic [LUMA_W-1:0] luma);
        int w, h, c, r, addr, diff;
        bit last_cell, act;
        t_motion_result res;
        w = clamp_grid(cfg_width, DEF_MAX_GRID_W);
        h = clamp_grid(cfg_height, DEF_MAX_GRID_H);
        if (cur_col >= w)
            cur_col = 0;
        if (cur_row >= h)
            cur_row = 0;
        c = cur_col;
        r = cur_row;
        addr = r * w + c;
        if (grid_primed) begin
            diff = int'(luma) - int'(prev_cells[addr]);
            if (diff < 0)
                diff = -diff;
            if (diff > int'(cfg_threshold)) begin
                if (change_count == 0) begin
                    least_col = c;
                    great_col = c;
                    least_row = r;
                    great_row = r;
                end else begin
                    if (c < least_col) least_col = c;
                    if (c > great_col) great_col = c;
                    if (r < least_row) least_row = r;
                    if (r > great_row) great_row = r;
                end
                change_count = change_count + 1'b1;
            end
        end
        prev_cells[addr] = luma;
        last_cell = (c + 1 == w) && (r + 1 == h);
        if (c + 1 == w) begin
            cur_col = 0;
            cur_row = r + 1;
        end else begin
            cur_col = c + 1;
        end
        if (last_cell) begin
            act = grid_primed && change_count != 0 && change_count >= cfg_min_cells;
            res.active = act;
            res.left   = act ? BOX_W'(least_col) : '0;
            res.top    = act ? BOX_W'(least_row) : '0;
            res.right  = act ? BOX_W'(great_col) : '0;
            res.bottom = act ? BOX_W'(great_row) : '0;
            res.count  = grid_primed ? change_count : '0;
            frame_results_due.push_back(res);
            grid_primed = 1'b1;
            restart_frame_model();
        end
    endtask

    // stays within threshold of the stored cell, but change_pct percent of cells jump anywhere
    function automatic logic [LUMA_W-1:0] next_luma();
        int w, h, c, r, p, d, v;
        w = clamp_grid(cfg_width, DEF_MAX_GRID_W);
        h = clamp_grid(cfg_height, DEF_MAX_GRID_H);
        c = (cur_col >= w) ? 0 : cur_col;
        r = (cur_row >= h) ? 0 : cur_row;
        if ($urandom_range(0, 99) < change_pct)
            return LUMA_W'($urandom_range(0, 255));
        p = prev_cells[r * w + c];
        d = $urandom_range(0, cfg_threshold);
        v = $urandom_range(0, 1) ? p + d : p - d;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return LUMA_W'(v);
    endfunction

    task automatic report_mismatch(string what, int got, int exp_val);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp_val, $realtime);
        mismatches++;
    endtask

    task automatic send_cell(logic [LUMA_W-1:0] luma);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= luma;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_cell(luma);
    endtask

    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        while (frame_results_due.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic apb_write(t_reg_idx idx, logic [31:0] word);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_GRID_W:    cfg_width = word[DIM_W-1:0];
            REG_GRID_H:    cfg_height = word[DIM_W-1:0];
            REG_THRESHOLD: cfg_threshold = word[LUMA_W-1:0];
            REG_MIN_CELLS: cfg_min_cells = word[COUNT_W-1:0];
        endcase
        grid_primed = 1'b0;
        restart_frame_model();
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] with_noise(logic [31:0] v, int bits);
        if ($urandom_range(0, 3) == 0)
            return v | ($urandom() << bits);
        return v;
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return DIM_W'($urandom_range(256, 511));
            2, 3:    return DIM_W'($urandom_range(13, 40));
            default: return DIM_W'($urandom_range(1, 12));
        endcase
    endfunction

    task automatic write_random_config(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
        int cells;
        logic [LUMA_W-1:0] thr;
        logic [COUNT_W-1:0] min_c;
        cells = clamp_grid(w, DEF_MAX_GRID_W) * clamp_grid(h, DEF_MAX_GRID_H);
        case ($urandom_range(0, 9))
            0:          thr = 8'd0;
            1:          thr = 8'd255;
            2, 3, 4:    thr = LUMA_W'($urandom_range(1, 10));
            default:    thr = LUMA_W'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2:    min_c = '0;
            3, 4, 5, 6: min_c = COUNT_W'($urandom_range(1, cells));
            7:          min_c = COUNT_W'($urandom_range(65536, 131071));
            default:    min_c = COUNT_W'($urandom_range(0, 131071));
        endcase
        apb_write(REG_GRID_W, with_noise(32'(w), DIM_W));
        apb_write(REG_GRID_H, with_noise(32'(h), DIM_W));
        apb_write(REG_THRESHOLD, with_noise(32'(thr), LUMA_W));
        apb_write(REG_MIN_CELLS, with_noise(32'(min_c), COUNT_W));
    endtask

    // default grid after reset, cut off partway, then a write restarts the frame
    task automatic test_midframe_write();
        int k;
        change_pct = 100;
        for (k = 0; k < 10; k++)
            send_cell(LUMA_W'($urandom_range(0, 255)));
        settle_block();
        apb_write(REG_GRID_W, 32'd0);
        apb_write(REG_GRID_H, 32'd0);
        apb_write(REG_THRESHOLD, 32'd0);
        apb_write(REG_MIN_CELLS, 32'd0);
    endtask

    // zero sizes act as a single cell; no change is inactive even with min_cells 0
    task automatic test_single_cell_grid();
        send_cell(8'd0);
        send_cell(8'd255);
        send_cell(8'd255);
        settle_block();
        apb_write(REG_THRESHOLD, 32'd255);
        send_cell(8'd0);
        send_cell(8'd255);
        settle_block();
    endtask

    task automatic test_corner_box();
        apb_write(REG_GRID_W, 32'd2);
        apb_write(REG_GRID_H, 32'd2);
        apb_write(REG_THRESHOLD, 32'd254);
        apb_write(REG_MIN_CELLS, 32'd1);
        send_cell(8'd0);
        send_cell(8'd0);
        send_cell(8'd0);
        send_cell(8'd0);
        send_cell(8'd255);
        send_cell(8'd0);
        send_cell(8'd0);
        send_cell(8'd255);
        send_cell(8'd7);
        send_cell(8'd7);
        settle_block();
        apb_write(REG_THRESHOLD, 32'd0);
        send_cell(8'd1);
        send_cell(8'd2);
        send_cell(8'd3);
        send_cell(8'd4);
        settle_block();
    endtask

    // one-cell frames while the receiver holds off, so the cell queue fills
    task automatic test_output_backpressure();
        int k;
        apb_write(REG_GRID_W, 32'd1);
        apb_write(REG_GRID_H, 32'd1);
        apb_write(REG_THRESHOLD, 32'd0);
        apb_write(REG_MIN_CELLS, 32'd0);
        tx_idle_en = 1'b0;
        hold_request = 1'b1;
        for (k = 0; k < 60; k++)
            send_cell(LUMA_W'($urandom_range(0, 255)));
        settle_block();
        tx_idle_en = 1'b1;
    endtask

    task automatic test_random_frames();
        int phase, cells, frames, f, k, partial;
        logic [DIM_W-1:0] w, h;
        phase = 0;
        while (rand_items < 1250 || rand_frames < 12) begin
            if (phase == 0) begin
                w = 9'd300;
                h = 9'd1;
            end else if (phase == 1) begin
                w = 9'd1;
                h = 9'd256;
            end else begin
                w = pick_dim();
                h = pick_dim();
                if (clamp_grid(w, DEF_MAX_GRID_W) * clamp_grid(h, DEF_MAX_GRID_H) > 600)
                    h = DIM_W'($urandom_range(1, 2));
            end
            write_random_config(w, h);
            cells = clamp_grid(w, DEF_MAX_GRID_W) * clamp_grid(h, DEF_MAX_GRID_H);
            frames = (cells > 200) ? 2 : $urandom_range(2, 5);
            case ($urandom_range(0, 4))
                0:       change_pct = 0;
                1:       change_pct = 3;
                2:       change_pct = 15;
                3:       change_pct = 60;
                default: change_pct = 100;
            endcase
            for (f = 0; f < frames; f++) begin
                for (k = 0; k < cells; k++)
                    send_cell(next_luma());
                rand_items += cells;
                rand_frames++;
            end
            if ($urandom_range(0, 4) == 0) begin
                partial = $urandom_range(0, cells - 1);
                for (k = 0; k < partial; k++)
                    send_cell(next_luma());
                rand_items += partial;
            end
            settle_block();
            phase++;
        end
    endtask

    // every cell changed: a count equal to min_cells is active, one short of it is not
    task automatic test_min_cells_edge();
        int k;
        apb_write(REG_GRID_W, 32'd4);
        apb_write(REG_GRID_H, 32'd4);
        apb_write(REG_THRESHOLD, 32'd0);
        apb_write(REG_MIN_CELLS, 32'd16);
        for (k = 0; k < 16; k++)
            send_cell(8'd0);
        for (k = 0; k < 16; k++)
            send_cell(8'd255);
        settle_block();
        apb_write(REG_MIN_CELLS, 32'd17);
        for (k = 0; k < 16; k++)
            send_cell(8'd0);
        for (k = 0; k < 16; k++)
            send_cell(8'd255);
        settle_block();
    endtask

    task automatic test_steady_stream();
        int f, k, cells;
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        write_random_config(DIM_W'($urandom_range(1, 12)), DIM_W'($urandom_range(1, 12)));
        cells = clamp_grid(cfg_width, DEF_MAX_GRID_W) * clamp_grid(cfg_height, DEF_MAX_GRID_H);
        change_pct = 20;
        for (f = 0; f < 4; f++)
            for (k = 0; k < cells; k++)
                send_cell(next_luma());
        settle_block();
    endtask

    // receiver: short random stalls, and a long hold-off when asked
    initial begin
        m_axis_tready <= 1'b0;
        hold_left = 0;
        rx_stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left = 400;
                m_axis_tready <= 1'b0;
            end else if (rx_stall_left > 0) begin
                rx_stall_left--;
                m_axis_tready <= 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                rx_stall_left = $urandom_range(1, 3) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // result checker
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                if (frame_results_due.size() == 0) begin
                    report_mismatch("unexpected result", m_axis_tdata[48:32], 0);
                end else begin
                    want = frame_results_due.pop_front();
                    if (m_axis_tuser[0] !== want.active)
                        report_mismatch("motion_active", m_axis_tuser[0], want.active);
                    if (m_axis_tdata[7:0] !== want.left)
                        report_mismatch("box_left", m_axis_tdata[7:0], want.left);
                    if (m_axis_tdata[15:8] !== want.top)
                        report_mismatch("box_top", m_axis_tdata[15:8], want.top);
                    if (m_axis_tdata[23:16] !== want.right)
                        report_mismatch("box_right", m_axis_tdata[23:16], want.right);
                    if (m_axis_tdata[31:24] !== want.bottom)
                        report_mismatch("box_bottom", m_axis_tdata[31:24], want.bottom);
                    if (m_axis_tdata[48:32] !== want.count)
                        report_mismatch("changed_cells", m_axis_tdata[48:32], want.count);
                    if (m_axis_tdata[55:49] !== 7'd0)
                        report_mismatch("tdata padding", m_axis_tdata[55:49], 0);
                end
            end
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        mismatches = 0;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        hold_request = 1'b0;
        change_pct = 100;
        rand_items = 0;
        rand_frames = 0;
        reset_model();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_midframe_write();
        test_single_cell_grid();
        test_corner_box();
        test_output_backpressure();
        test_random_frames();
        test_min_cells_edge();
        test_steady_stream();

        settle_block();
        if (mismatches == 0 && frame_results_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: grid_motion_diff_bbox.f
hw/rtl/gmdb_pkg.sv
hw/rtl/gmdb_fifo.sv
hw/rtl/gmdb_front.sv
hw/rtl/gmdb_back.sv
hw/rtl/grid_motion_diff_bbox.sv
bench/tb_grid_motion_diff_bbox.sv
